/* src/gsls_pkg.sv */
// Package for the Gauss-Seidel solver: widths, register indexes, opcodes,
// sequencer states and shared structs. No dependencies.
package gsls_pkg;

  localparam int MaxOrder = 16;
  localparam int IdxW     = (MaxOrder > 1) ? $clog2(MaxOrder) : 1;
  localparam int MatW     = 2 * IdxW;

  localparam logic [6:0]  OrderReset = 7'd16;
  localparam logic [15:0] IterReset  = 16'd1000;
  localparam logic [62:0] TolReset   = 63'd43;

  typedef enum logic [1:0] {
    REG_ORDER = 2'd0,
    REG_ITER  = 2'd1,
    REG_TOL   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_MATRIX = 2'd0,
    OP_RHS    = 2'd1,
    OP_GUESS  = 2'd2,
    OP_SOLVE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_ZERO_DIAG = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DCHK, S_DCHK_W, S_ROW, S_MAC_RD, S_MAC_MUL, S_MAC_ACC,
    S_DIV_RD, S_DIV, S_UPD, S_SQ, S_NORM, S_EMIT_RD, S_EMIT
  } seq_state_e;

  // divider request / response
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [63:0] sat_sub64(logic signed [63:0] a,
                                                   logic signed [63:0] p);
    logic signed [63:0] r;
    r = a - p;
    if (a[63] != p[63] && r[63] != a[63]) r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return r;
  endfunction

endpackage

/* src/gsls_if.sv */
// Valid/ready channel interfaces for the solver.
// No dependencies.
interface gsls_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [5:0]  row_index;
  logic [5:0]  column_index;
  logic signed [31:0] entry_value;
  modport source (output valid, opcode, row_index, column_index, entry_value, input ready);
  modport sink   (input valid, opcode, row_index, column_index, entry_value, output ready);
endinterface

interface gsls_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  result_index;
  logic signed [31:0] solution_value;
  logic        last_of_run;
  logic [1:0]  solve_status;
  logic [15:0] sweeps_done;
  modport source (output valid, result_index, solution_value, last_of_run, solve_status,
                  sweeps_done, input ready);
  modport sink   (input valid, result_index, solution_value, last_of_run, solve_status,
                  sweeps_done, output ready);
endinterface

interface gsls_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [62:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/gsls_div.sv */
// Restoring signed divider, one quotient bit per cycle.
// Truncates toward zero and saturates to signed 32 bits. Depends on gsls_pkg.
module gsls_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  gsls_pkg::div_req_t req_i,
  output gsls_pkg::div_rsp_t rsp_o
);
  import gsls_pkg::*;

  logic [63:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;
  logic [64:0] sq;

  always_comb begin
    trial  = {rem_q, quo_q[63]} - {33'd0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend[63] ? (~req_i.dividend + 64'd1) : req_i.dividend;
      dvs_d  = req_i.divisor[31] ? (~req_i.divisor + 32'd1) : req_i.divisor;
      neg_d  = req_i.dividend[63] ^ req_i.divisor[31];
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // magnitude quotient -> signed saturate
  always_comb begin
    sq = neg_q ? (65'd0 - {1'b0, quo_q}) : {1'b0, quo_q};
    if (!neg_q && quo_q > 64'h7FFF_FFFF) rsp_o.quot = 32'h7FFF_FFFF;
    else if (neg_q && quo_q > 64'h8000_0000) rsp_o.quot = 32'h8000_0000;
    else rsp_o.quot = sq[31:0];
    rsp_o.done = done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end
endmodule

/* src/gsls_store.sv */
// Matrix, right-hand side and solution memories with registered reads.
// Depends on gsls_pkg.
module gsls_store (
  input  logic clk_i,
  input  logic                    mat_we_i,
  input  logic [gsls_pkg::MatW-1:0] mat_waddr_i,
  input  logic [gsls_pkg::MatW-1:0] mat_raddr_i,
  input  logic [31:0]             mat_wdata_i,
  output logic [31:0]             mat_rdata_o,
  input  logic                    vec_we_i,
  input  logic                    vec_sel_i,
  input  logic [gsls_pkg::IdxW-1:0] vec_waddr_i,
  input  logic [31:0]             vec_wdata_i,
  input  logic [gsls_pkg::IdxW-1:0] rhs_raddr_i,
  output logic [31:0]             rhs_rdata_o,
  input  logic [gsls_pkg::IdxW-1:0] x_raddr_i,
  output logic [31:0]             x_rdata_o
);
  import gsls_pkg::*;

  logic [31:0] mat_mem [MaxOrder*MaxOrder];
  logic [31:0] rhs_mem [MaxOrder];
  logic [31:0] x_mem   [MaxOrder];

  always_ff @(posedge clk_i) begin
    if (mat_we_i) mat_mem[mat_waddr_i] <= mat_wdata_i;
    mat_rdata_o <= mat_mem[mat_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (vec_we_i && !vec_sel_i) rhs_mem[vec_waddr_i] <= vec_wdata_i;
    rhs_rdata_o <= rhs_mem[rhs_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (vec_we_i && vec_sel_i) x_mem[vec_waddr_i] <= vec_wdata_i;
    x_rdata_o <= x_mem[x_raddr_i];
  end
endmodule

/* src/gauss_seidel_linear_solver.sv */
// Top level of the Gauss-Seidel solver: config registers, sequencer, shared
// multiplier and accumulator. Depends on gsls_pkg, gsls_if, gsls_store, gsls_div.
//
// Loads (matrix, rhs, guess) may follow back to back. A solve first checks the n
// diagonals, row by row through S_DCHK and S_DCHK_W, and stops at the first zero
// one. Each sweep then walks the matrix through one read port, with one 33x33
// multiplier shared by the products and the update squares. Each row ends with a
// division in the bit-serial divider. Results then stream out through S_EMIT_RD
// and S_EMIT, each held until the sink is ready. The block takes no new request
// until the last result of a solve has been delivered.
module gauss_seidel_linear_solver (
  input  logic clk_i,
  input  logic rst_ni,
  gsls_in_if.sink    in_if,
  gsls_cfg_if.sink   cfg_if,
  gsls_out_if.source out_if
);
  import gsls_pkg::*;

  logic [6:0]  order_q;
  logic [15:0] iter_q;
  logic [62:0] tol_q;

  seq_state_e state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, n1_q, n1_d;
  logic [15:0] sw_q, sw_d;
  logic [1:0]  stat_q, stat_d;
  logic signed [63:0] acc_q, acc_d, prod_q, prod_d;
  logic [63:0] norm_q, norm_d, sq_q, sq_d;
  logic signed [31:0] nx_q, nx_d;
  logic        zd_q, zd_d;

  logic [MatW-1:0] mat_raddr;
  logic [IdxW-1:0] rhs_raddr, x_raddr, vec_waddr;
  logic [31:0] mat_rd, rhs_rd, x_rd, vec_wdata;
  logic mat_we, vec_we, vec_sel;
  div_req_t dreq;
  div_rsp_t drsp;

  logic in_fire, in_rng;
  logic [6:0] n_eff;
  logic signed [32:0] delta;
  logic [32:0] mag;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [63:0] norm_sum;
  logic converged, last_sweep;

  assign cfg_if.ready = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
      iter_q  <= IterReset;
      tol_q   <= TolReset;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_ORDER: order_q <= cfg_if.data[6:0];
        REG_ITER:  iter_q  <= cfg_if.data[15:0];
        REG_TOL:   tol_q   <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign n_eff = (order_q == 7'd0) ? 7'd1 :
                 (order_q > 7'(MaxOrder)) ? 7'(MaxOrder) : order_q;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign in_rng      = (32'(in_if.row_index) < 32'(MaxOrder));

  // load path shares the vector write port with the x update
  always_comb begin
    mat_we    = in_fire && in_if.opcode == OP_MATRIX && in_rng &&
                (32'(in_if.column_index) < 32'(MaxOrder));
    vec_we    = 1'b0;
    vec_sel   = 1'b1;
    vec_waddr = in_if.row_index[IdxW-1:0];
    vec_wdata = in_if.entry_value;
    if (in_fire && in_rng && in_if.opcode == OP_RHS) begin
      vec_we = 1'b1; vec_sel = 1'b0;
    end else if (in_fire && in_rng && in_if.opcode == OP_GUESS) begin
      vec_we = 1'b1;
    end else if (state_q == S_SQ) begin
      vec_we = 1'b1; vec_waddr = i_q; vec_wdata = nx_q;
    end
  end

  gsls_store u_store (
    .clk_i, .mat_we_i(mat_we),
    .mat_waddr_i({in_if.row_index[IdxW-1:0], in_if.column_index[IdxW-1:0]}),
    .mat_raddr_i(mat_raddr), .mat_wdata_i(in_if.entry_value), .mat_rdata_o(mat_rd),
    .vec_we_i(vec_we), .vec_sel_i(vec_sel), .vec_waddr_i(vec_waddr),
    .vec_wdata_i(vec_wdata), .rhs_raddr_i(rhs_raddr), .rhs_rdata_o(rhs_rd),
    .x_raddr_i(x_raddr), .x_rdata_o(x_rd)
  );

  gsls_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign delta = 33'(nx_q) - 33'(signed'(x_rd));
  assign mag   = delta[32] ? (33'd0 - delta) : delta;

  // shared multiplier: A*x during the row walk, update squared in S_SQ
  assign mul_a = (state_q == S_SQ) ? signed'({1'b0, mag[31:0]}) : 33'(signed'(mat_rd));
  assign mul_b = (state_q == S_SQ) ? signed'({1'b0, mag[31:0]}) : 33'(signed'(x_rd));
  assign mul_p = mul_a * mul_b;

  // sweep norm and stop conditions
  assign norm_sum   = (norm_q > ~sq_q) ? {64{1'b1}} : norm_q + sq_q;
  assign converged  = (norm_sum <= {1'b0, tol_q});
  assign last_sweep = (sw_q + 16'd1 == iter_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_fire && in_if.opcode == OP_SOLVE) state_d = S_DCHK;
      S_DCHK:    state_d = S_DCHK_W;
      S_DCHK_W:  if (mat_rd == 32'd0) state_d = S_EMIT_RD;
                 else if (i_q != n1_q) state_d = S_DCHK;
                 else if (iter_q == 16'd0) state_d = S_EMIT_RD;
                 else state_d = S_ROW;
      S_ROW:     state_d = (n1_q == '0) ? S_DIV_RD : S_MAC_RD;
      S_MAC_RD:  state_d = S_MAC_MUL;
      S_MAC_MUL: state_d = S_MAC_ACC;
      S_MAC_ACC: state_d = S_DIV_RD;
      S_DIV_RD:  state_d = S_DIV;
      S_DIV:     if (drsp.done) state_d = S_UPD;
      S_UPD:     state_d = S_SQ;
      S_SQ:      state_d = S_NORM;
      S_NORM:    if (i_q != n1_q) state_d = S_ROW;
                 else if (converged || last_sweep) state_d = S_EMIT_RD;
                 else state_d = S_ROW;
      S_EMIT_RD: state_d = S_EMIT;
      S_EMIT:    if (out_if.ready) state_d = (i_q == n1_q) ? S_IDLE : S_EMIT_RD;
      default:   state_d = S_IDLE;
    endcase
    if (state_q == S_MAC_ACC) begin
      // more columns to go
      if (!(j_q == n1_q || (j_q + IdxW'(1) == i_q && i_q == n1_q))) state_d = S_MAC_RD;
    end
  end

  // datapath
  always_comb begin
    i_d = i_q; j_d = j_q; n1_d = n1_q; sw_d = sw_q; stat_d = stat_q;
    acc_d = acc_q; prod_d = prod_q; norm_d = norm_q; sq_d = sq_q;
    nx_d = nx_q; zd_d = zd_q;
    mat_raddr = {i_q, i_q}; rhs_raddr = i_q; x_raddr = i_q;
    dreq = '{start: 1'b0, dividend: acc_q, divisor: mat_rd};
    unique case (state_q)
      S_IDLE: begin
        i_d = '0; n1_d = IdxW'(n_eff - 7'd1); sw_d = '0;
      end
      S_DCHK: ;
      S_DCHK_W: begin
        if (mat_rd == 32'd0) begin stat_d = ST_ZERO_DIAG; i_d = '0; end
        else if (i_q != n1_q) i_d = i_q + IdxW'(1);
        else begin
          i_d = '0; stat_d = ST_LIMIT; norm_d = '0;
        end
      end
      S_ROW: begin
        j_d = (i_q == '0) ? IdxW'(1) : '0;
      end
      S_MAC_RD: begin
        mat_raddr = {i_q, j_q}; x_raddr = j_q;
      end
      S_MAC_MUL: begin
        prod_d = mul_p[63:0];
        if (j_q == ((i_q == '0) ? IdxW'(1) : IdxW'(0))) acc_d = 64'(signed'(rhs_rd)) <<< 16;
      end
      S_MAC_ACC: begin
        acc_d = sat_sub64(acc_q, prod_q);
        j_d = (j_q + IdxW'(1) == i_q) ? j_q + IdxW'(2) : j_q + IdxW'(1);
      end
      S_DIV_RD: begin
        if (n1_q == '0) acc_d = 64'(signed'(rhs_rd)) <<< 16;
      end
      S_DIV: begin
        dreq.start = (state_q == S_DIV) && !zd_q;
        zd_d = 1'b1;
        if (drsp.done) begin nx_d = drsp.quot; zd_d = 1'b0; end
      end
      S_UPD: ;
      S_SQ: begin
        sq_d = mag[32] ? {64{1'b1}} : mul_p[63:0];
      end
      S_NORM: begin
        norm_d = norm_sum;
        if (i_q != n1_q) i_d = i_q + IdxW'(1);
        else begin
          i_d = '0; sw_d = sw_q + 16'd1;
          if (converged) stat_d = ST_CONVERGED;
          if (!(converged || last_sweep)) norm_d = '0;
        end
      end
      S_EMIT_RD: ;
      S_EMIT: if (out_if.ready) i_d = i_q + IdxW'(1);
      default: ;
    endcase
  end

  assign out_if.valid          = (state_q == S_EMIT);
  assign out_if.result_index   = 6'(i_q);
  assign out_if.solution_value = x_rd;
  assign out_if.last_of_run    = (i_q == n1_q);
  assign out_if.solve_status   = stat_q;
  assign out_if.sweeps_done    = sw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0; j_q <= '0; n1_q <= '0; sw_q <= '0; stat_q <= ST_CONVERGED; zd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; j_q <= j_d; n1_q <= n1_d; sw_q <= sw_d; stat_q <= stat_d;
      zd_q <= (state_d == S_DIV) ? zd_d : 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; prod_q <= prod_d; norm_q <= norm_d; sq_q <= sq_d;
    nx_q <= nx_d;
  end
endmodule

/* src/gsls_checker.sv */
// Port-level checker for the solver, bound to the top level.
// Depends on gsls_pkg and the channel interfaces.
module gsls_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready, out_valid, out_ready, out_last,
  input logic [1:0] out_status,
  input logic [15:0] out_sweeps
);
  import gsls_pkg::*;

  // no request taken while results stream
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input ready during output");

  // zero diagonal reports no sweeps
  a_zd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_status == ST_ZERO_DIAG) |-> out_sweeps == 16'd0)
    else $error("sweeps on zero diagonal");

  // status is a legal code
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_status != 2'd3) else $error("bad status");

  // stalled output holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid && $stable(out_last))
    else $error("output dropped");
endmodule

bind gauss_seidel_linear_solver gsls_checker u_chk (
  .clk_i, .rst_ni,
  .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_last(out_if.last_of_run),
  .out_status(out_if.solve_status), .out_sweeps(out_if.sweeps_done)
);
